### src/spq_pkg.sv
// spq_pkg: command, status and sequencer state types for the stable priority queue
// no dependencies; imported by stable_priority_queue_core
package spq_pkg;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_FIND  = 2'd2,
        CMD_ERASE = 2'd3
    } spq_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } spq_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_PUSH_WALK,
        S_PUSH_LAST,
        S_RESP
    } spq_state_t;

endpackage

### src/stable_priority_queue_core.sv
// stable_priority_queue_core: sorted-list priority queue held in one entry memory
// walked by a single read/write sequencer; depends on spq_pkg
//
//   channel  ports                                              direction
//   input    s_valid s_ready s_command s_entry_key s_entry_priority   in
//   result   m_valid m_ready m_result_status m_result_key m_result_priority
//            m_position m_entry_count m_head_valid m_head_key m_head_priority  out
//
// one memory read and one memory write per cycle set the pace: a push walks past the
// entries above its insertion point, a find scans up to its match position, and a pop or
// erase scans to its match and then shifts the entries behind it forward. s_ready is
// high only while idle. a finished result waits in the output register, so a stalled
// m_ready only holds the block in its response step. aresetn empties the queue; no
// clearing pass is needed.
module stable_priority_queue_core #(
    parameter int DEPTH         = 16,
    parameter int KEY_BITS      = 32,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [spq_pkg::CMD_W-1:0]               s_command,
    input  logic [KEY_BITS-1:0]                     s_entry_key,
    input  logic [PRIORITY_BITS-1:0]                s_entry_priority,

    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [spq_pkg::STATUS_W-1:0]            m_result_status,
    output logic [KEY_BITS-1:0]                     m_result_key,
    output logic [PRIORITY_BITS-1:0]                m_result_priority,
    output logic [$clog2(DEPTH+1)-1:0]              m_position,
    output logic [$clog2(DEPTH+1)-1:0]              m_entry_count,
    output logic                                    m_head_valid,
    output logic [KEY_BITS-1:0]                     m_head_key,
    output logic [PRIORITY_BITS-1:0]                m_head_priority
);
    import spq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    // entry memory, slot 0 is the head
    logic [KEY_BITS-1:0]      key_mem  [DEPTH];
    logic [PRIORITY_BITS-1:0] prio_mem [DEPTH];
    logic [KEY_BITS-1:0]      rd_key_reg;
    logic [PRIORITY_BITS-1:0] rd_prio_reg;

    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [KEY_BITS-1:0]      wr_key;
    logic [PRIORITY_BITS-1:0] wr_prio;
    logic [IDX_W-1:0]         rd_addr;

    spq_state_t               state_reg, state_next;
    spq_cmd_t                 cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]      key_reg, key_next;
    logic [PRIORITY_BITS-1:0] prio_reg, prio_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [KEY_BITS-1:0]      head_key_reg, head_key_next;
    logic [PRIORITY_BITS-1:0] head_prio_reg, head_prio_next;

    spq_status_t              res_status_reg, res_status_next;
    logic [KEY_BITS-1:0]      res_key_reg, res_key_next;
    logic [PRIORITY_BITS-1:0] res_prio_reg, res_prio_next;
    logic [CNT_W-1:0]         res_pos_reg, res_pos_next;

    logic                     m_valid_reg, m_valid_next;
    spq_status_t              m_status_reg, m_status_next;
    logic [KEY_BITS-1:0]      m_key_reg, m_key_next;
    logic [PRIORITY_BITS-1:0] m_prio_reg, m_prio_next;
    logic [CNT_W-1:0]         m_pos_reg, m_pos_next;
    logic [CNT_W-1:0]         m_count_reg, m_count_next;
    logic                     m_hvalid_reg, m_hvalid_next;
    logic [KEY_BITS-1:0]      m_hkey_reg, m_hkey_next;
    logic [PRIORITY_BITS-1:0] m_hprio_reg, m_hprio_next;

    spq_cmd_t                 s_cmd;
    logic                     accept;
    logic                     out_free;
    logic [CNT_W-1:0]         idx_inc;
    logic [CNT_W-1:0]         idx_inc2;
    logic [CNT_W-1:0]         cnt_dec;
    logic                     is_last;
    logic                     shift_done;
    logic                     match;
    logic                     prio_greater;
    logic                     cnt_full;
    logic                     cnt_empty;

    assign s_cmd        = spq_cmd_t'(s_command);
    assign s_ready      = (state_reg == S_IDLE);
    assign accept       = s_valid && s_ready;
    assign out_free     = !m_valid_reg || m_ready;
    assign idx_inc      = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_inc2     = CNT_W'(idx_reg) + CNT_W'(2);
    assign cnt_dec      = cnt_reg - CNT_W'(1);
    assign is_last      = (idx_inc == cnt_reg);
    assign shift_done   = (idx_inc2 == cnt_reg);
    // pop always takes the entry at the head
    assign match        = (cmd_reg == CMD_POP) || (rd_key_reg == key_reg);
    assign prio_greater = (rd_prio_reg > prio_reg);
    assign cnt_full     = (cnt_reg == CNT_W'(DEPTH));
    assign cnt_empty    = (cnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr]  <= wr_key;
            prio_mem[wr_addr] <= wr_prio;
        end
        rd_key_reg  <= key_mem[rd_addr];
        rd_prio_reg <= prio_mem[rd_addr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (s_cmd) inside
                        CMD_PUSH: begin
                            if (cnt_full) begin
                                state_next = S_RESP;
                            end else if (cnt_empty) begin
                                state_next = S_PUSH_LAST;
                            end else begin
                                state_next = S_PUSH_WALK;
                            end
                        end
                        CMD_POP, CMD_FIND, CMD_ERASE: begin
                            state_next = cnt_empty ? S_RESP : S_SCAN;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (match) begin
                    state_next = (cmd_reg == CMD_FIND || is_last) ? S_RESP : S_SHIFT;
                end else if (is_last) begin
                    state_next = S_RESP;
                end
            end
            S_SHIFT: begin
                if (shift_done) begin
                    state_next = S_RESP;
                end
            end
            S_PUSH_WALK: begin
                if (prio_greater) begin
                    if (idx_reg == '0) begin
                        state_next = S_PUSH_LAST;
                    end
                end else begin
                    state_next = S_RESP;
                end
            end
            S_PUSH_LAST: state_next = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        prio_next       = prio_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_prio_next   = res_prio_reg;
        res_pos_next    = res_pos_reg;
        m_status_next   = m_status_reg;
        m_key_next      = m_key_reg;
        m_prio_next     = m_prio_reg;
        m_pos_next      = m_pos_reg;
        m_count_next    = m_count_reg;
        m_hvalid_next   = m_hvalid_reg;
        m_hkey_next     = m_hkey_reg;
        m_hprio_next    = m_hprio_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_key          = key_reg;
        wr_prio         = prio_reg;
        rd_addr         = idx_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next      = s_cmd;
                    key_next      = s_entry_key;
                    prio_next     = s_entry_priority;
                    res_key_next  = '0;
                    res_prio_next = '0;
                    res_pos_next  = '0;
                    unique case (s_cmd) inside
                        CMD_PUSH: begin
                            res_status_next = cnt_full ? STAT_FULL : STAT_OK;
                            // walk down from the tail
                            idx_next = cnt_dec[IDX_W-1:0];
                            rd_addr  = cnt_dec[IDX_W-1:0];
                        end
                        CMD_POP: begin
                            res_status_next = STAT_EMPTY;
                            idx_next        = '0;
                            rd_addr         = '0;
                        end
                        CMD_FIND, CMD_ERASE: begin
                            res_status_next = STAT_NOT_FOUND;
                            idx_next        = '0;
                            rd_addr         = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                rd_addr = idx_inc[IDX_W-1:0];
                if (match) begin
                    res_status_next = STAT_OK;
                    res_key_next    = rd_key_reg;
                    res_prio_next   = rd_prio_reg;
                    res_pos_next    = idx_inc;
                    if (cmd_reg != CMD_FIND && is_last) begin
                        cnt_next = cnt_dec;
                    end
                end else if (!is_last) begin
                    idx_next = idx_inc[IDX_W-1:0];
                end
            end
            S_SHIFT: begin
                // read data holds the entry behind the slot being refilled
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_key  = rd_key_reg;
                wr_prio = rd_prio_reg;
                rd_addr = idx_inc2[IDX_W-1:0];
                if (shift_done) begin
                    cnt_next = cnt_dec;
                end else begin
                    idx_next = idx_inc[IDX_W-1:0];
                end
            end
            S_PUSH_WALK: begin
                wr_en   = 1'b1;
                wr_addr = idx_inc[IDX_W-1:0];
                rd_addr = idx_reg - IDX_W'(1);
                if (prio_greater) begin
                    wr_key  = rd_key_reg;
                    wr_prio = rd_prio_reg;
                    if (idx_reg != '0) begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end else begin
                    // equal priorities stay ahead of the new entry
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_PUSH_LAST: begin
                wr_en    = 1'b1;
                wr_addr  = '0;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_key_next    = res_key_reg;
                    m_prio_next   = res_prio_reg;
                    m_pos_next    = res_pos_reg;
                    m_count_next  = cnt_reg;
                    m_hvalid_next = !cnt_empty;
                    m_hkey_next   = cnt_empty ? '0 : head_key_reg;
                    m_hprio_next  = cnt_empty ? '0 : head_prio_reg;
                end
            end
            default: ;
        endcase

        // shadow copy of slot 0
        head_key_next  = head_key_reg;
        head_prio_next = head_prio_reg;
        if (wr_en && wr_addr == '0) begin
            head_key_next  = wr_key;
            head_prio_next = wr_prio;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        prio_reg       <= prio_next;
        idx_reg        <= idx_next;
        head_key_reg   <= head_key_next;
        head_prio_reg  <= head_prio_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_prio_reg   <= res_prio_next;
        res_pos_reg    <= res_pos_next;
        m_status_reg   <= m_status_next;
        m_key_reg      <= m_key_next;
        m_prio_reg     <= m_prio_next;
        m_pos_reg      <= m_pos_next;
        m_count_reg    <= m_count_next;
        m_hvalid_reg   <= m_hvalid_next;
        m_hkey_reg     <= m_hkey_next;
        m_hprio_reg    <= m_hprio_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_result_status   = m_status_reg;
    assign m_result_key      = m_key_reg;
    assign m_result_priority = m_prio_reg;
    assign m_position        = m_pos_reg;
    assign m_entry_count     = m_count_reg;
    assign m_head_valid      = m_hvalid_reg;
    assign m_head_key        = m_hkey_reg;
    assign m_head_priority   = m_hprio_reg;

endmodule
